// ----- design/rcfd_pkg.sv -----
package rcfd_pkg;

    localparam int FRAME_BYTES   = 26;
    localparam int CHANNEL_COUNT = 16;
    localparam int DATA_BYTES    = 22;
    localparam int RAW_W         = 11;
    localparam int CH_W          = 4;
    localparam int VALUE_W       = 16;
    localparam int POS_W         = 5;
    localparam int QUOT_W        = VALUE_W - RAW_W;
    localparam int DATA_W        = DATA_BYTES * 8;

    localparam logic [10:0] RAW_MAX = 11'h7FF;

    localparam logic [4:0] POS_SYNC       = 5'd0;
    localparam logic [4:0] POS_LENGTH     = 5'd1;
    localparam logic [4:0] POS_TYPE       = 5'd2;
    localparam logic [4:0] POS_DATA_FIRST = 5'd3;
    localparam logic [4:0] POS_DATA_LAST  = 5'd24;
    localparam logic [4:0] POS_CHECK      = 5'd25;

    localparam logic OP_BYTE  = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    localparam logic [1:0] CFG_SYNC_ADDRESS = 2'd0;
    localparam logic [1:0] CFG_FRAME_TYPE   = 2'd1;
    localparam logic [1:0] CFG_MAX_LENGTH   = 2'd2;

    localparam logic [7:0] SYNC_ADDRESS_RST = 8'hC8;
    localparam logic [7:0] FRAME_TYPE_RST   = 8'h16;
    localparam logic [7:0] MAX_LENGTH_RST   = 8'd64;

    typedef struct packed {
        logic       operation;
        logic [7:0] data_byte;
    } byte_item_t;

    typedef struct packed {
        logic [3:0]  channel_index;
        logic [15:0] channel_value;
        logic [10:0] raw_value;
        logic        last_channel;
    } result_item_t;

endpackage

// ----- design/rc_channel_frame_decoder.sv -----
// Packed RC channel frame decoder. Serial bytes enter one per transaction on the byte
// channel and are taken one per cycle while a frame is assembled: sync address, length
// (frames whose length exceeds max_length are dropped), type, 22 data bytes and an
// unchecked check byte. A flush transaction discards a partial frame. When the check
// byte of a frame whose type matches frame_type arrives, the block stalls the byte
// channel and emits sixteen result transactions, channel 0 first, the last one marked.
// Each channel passes twice through one shared scaling unit (a shift-subtract multiply
// by 31, then a divide-by-2047 correction); the byte channel stays stalled until the
// last channel is emitted. The sync, type and length registers are written over the
// cfg channel; the user must write them only while the block is idle (not enforced).
module rc_channel_frame_decoder (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  byte_valid,
    output logic                  byte_stall,
    input  rcfd_pkg::byte_item_t  byte_data,
    output logic                  result_valid,
    input  logic                  result_stall,
    output rcfd_pkg::result_item_t result_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [7:0]            cfg_data
);
    import rcfd_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CALC = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [CH_W-1:0]   ch_reg, ch_next;
    logic              result_valid_reg, result_valid_next;
    logic [7:0]        sync_address_reg, frame_type_reg, max_length_reg;

    logic [DATA_W-1:0] data_reg;
    logic [7:0]        type_reg;
    logic [RAW_W-1:0]  raw_reg;
    logic [VALUE_W-1:0] prod_reg;
    result_item_t      result_reg;

    logic              byte_fire;
    logic              emit_fire;
    logic              frame_done;
    logic [QUOT_W-1:0] quot_est;
    logic [RAW_W:0]    rem_est;
    logic [QUOT_W-1:0] quot;

    assign cfg_ready    = 1'b1;
    assign byte_stall   = (state_reg != ST_IDLE);
    assign byte_fire    = byte_valid && !byte_stall;
    assign emit_fire    = (state_reg == ST_EMIT) && (!result_valid_reg || !result_stall);
    assign result_valid = result_valid_reg;
    assign result_data  = result_reg;

    // floor(x / 2047) = floor(x / 2048) + 1 when the remainder estimate reaches 2047
    assign quot_est = prod_reg[VALUE_W-1:RAW_W];
    assign rem_est  = {1'b0, prod_reg[RAW_W-1:0]} + {{(RAW_W+1-QUOT_W){1'b0}}, quot_est};
    assign quot     = quot_est + QUOT_W'(rem_est >= {1'b0, RAW_MAX});

    assign frame_done = byte_fire && (byte_data.operation == OP_BYTE)
                        && (pos_reg == POS_CHECK);

    always_comb
    begin
        pos_next = pos_reg;
        if (byte_fire)
        begin
            if (byte_data.operation == OP_FLUSH)
            begin
                pos_next = POS_SYNC;
            end
            else
            begin
                case (pos_reg) inside
                    POS_SYNC:
                    begin
                        pos_next = (byte_data.data_byte == sync_address_reg)
                                   ? POS_LENGTH : POS_SYNC;
                    end
                    POS_LENGTH:
                    begin
                        pos_next = (byte_data.data_byte > max_length_reg)
                                   ? POS_SYNC : POS_TYPE;
                    end
                    [POS_TYPE:POS_DATA_LAST]:
                    begin
                        pos_next = pos_reg + POS_W'(1);
                    end
                    default:
                    begin
                        pos_next = POS_SYNC;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        ch_next           = ch_reg;
        result_valid_next = result_valid_reg;
        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (frame_done && (type_reg == frame_type_reg))
                begin
                    state_next = ST_CALC;
                    ch_next    = '0;
                end
            end
            ST_CALC:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (emit_fire)
                begin
                    result_valid_next = 1'b1;
                    ch_next           = ch_reg + CH_W'(1);
                    state_next        = (ch_reg == CH_W'(CHANNEL_COUNT - 1))
                                        ? ST_IDLE : ST_CALC;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            pos_reg          <= POS_SYNC;
            ch_reg           <= '0;
            result_valid_reg <= 1'b0;
            sync_address_reg <= SYNC_ADDRESS_RST;
            frame_type_reg   <= FRAME_TYPE_RST;
            max_length_reg   <= MAX_LENGTH_RST;
        end
        else
        begin
            state_reg        <= state_next;
            pos_reg          <= pos_next;
            ch_reg           <= ch_next;
            result_valid_reg <= result_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_SYNC_ADDRESS: sync_address_reg <= cfg_data;
                    CFG_FRAME_TYPE:   frame_type_reg   <= cfg_data;
                    CFG_MAX_LENGTH:   max_length_reg   <= cfg_data;
                    default:          ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_fire && (byte_data.operation == OP_BYTE))
        begin
            if (pos_reg == POS_TYPE)
            begin
                type_reg <= byte_data.data_byte;
            end
            if ((pos_reg >= POS_DATA_FIRST) && (pos_reg <= POS_DATA_LAST))
            begin
                data_reg <= {byte_data.data_byte, data_reg[DATA_W-1:8]};
            end
        end
        if (state_reg == ST_CALC)
        begin
            raw_reg  <= data_reg[RAW_W-1:0];
            prod_reg <= {data_reg[RAW_W-1:0], {QUOT_W{1'b0}}}
                        - {{QUOT_W{1'b0}}, data_reg[RAW_W-1:0]};
        end
        if (emit_fire)
        begin
            data_reg                 <= data_reg >> RAW_W;
            result_reg.channel_index <= ch_reg;
            result_reg.channel_value <= {raw_reg, quot};
            result_reg.raw_value     <= raw_reg;
            result_reg.last_channel  <= (ch_reg == CH_W'(CHANNEL_COUNT - 1));
        end
    end

`ifndef SYNTHESIS
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_CHECK)
        else $error("byte position out of frame");

    a_pos_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (pos_reg == POS_SYNC))
        else $error("byte position not cleared while emitting");

    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_data.last_channel)
        |-> (result_data.channel_index == CH_W'(CHANNEL_COUNT - 1)))
        else $error("last channel flag on wrong index");

    a_scale_high: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result_data.channel_value[VALUE_W-1:QUOT_W]
                          == result_data.raw_value))
        else $error("scaled value disagrees with raw value");

    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_fire && (ch_reg == CH_W'(CHANNEL_COUNT - 1))) |=> (state_reg == ST_IDLE))
        else $error("sequencer did not return to idle after last channel");
`endif

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
    import rcfd_pkg::*;

    typedef enum logic [1:0] {ROW_FRAME, ROW_BAD_SYNC, ROW_CUT_FLUSH, ROW_FLUSH_IDLE} row_kind_t;
    typedef enum logic [1:0] {FILL_CONST, FILL_RAMP, FILL_RAND, FILL_EDGE} fill_t;

    typedef struct packed {
        row_kind_t   kind;
        fill_t       fill_mode;
        logic [7:0]  fill;
        logic [7:0]  length;
        logic [7:0]  ftype;
        logic [7:0]  check;
        logic [4:0]  cut;
        logic        typed;
        logic [10:0] t_raw;
        logic [15:0] t_value;
    } stim_row_t;

    localparam int ROWS = 13;

    stim_row_t stim_table [ROWS] = '{
        '{ROW_FRAME,      FILL_CONST, 8'hFF, 8'd24, FRAME_TYPE_RST, 8'h5A, 5'd0, 1'b1,
          RAW_MAX, 16'hFFFF},
        '{ROW_FRAME,      FILL_CONST, 8'h00, 8'd0, FRAME_TYPE_RST, 8'h00, 5'd0, 1'b1,
          11'd0, 16'd0},
        '{ROW_FRAME,      FILL_RAMP, 8'h00, MAX_LENGTH_RST, FRAME_TYPE_RST, 8'hFF, 5'd0, 1'b0,
          11'd0, 16'd0},
        '{ROW_FRAME,      FILL_CONST, 8'h55, 8'd1, FRAME_TYPE_RST, 8'hAA, 5'd0, 1'b0,
          11'd0, 16'd0},
        '{ROW_FRAME,      FILL_CONST, 8'hAA, 8'd2, FRAME_TYPE_RST, 8'h55, 5'd0, 1'b0,
          11'd0, 16'd0},
        '{ROW_BAD_SYNC,   FILL_CONST, 8'hFF, 8'd24, FRAME_TYPE_RST, 8'h33, 5'd0, 1'b1,
          RAW_MAX, 16'hFFFF},
        '{ROW_FRAME,      FILL_CONST, 8'hFF, MAX_LENGTH_RST + 8'd1, FRAME_TYPE_RST, 8'hFF,
          5'd0, 1'b0, 11'd0, 16'd0},
        '{ROW_FRAME,      FILL_CONST, 8'h00, 8'hFF, FRAME_TYPE_RST, 8'h00, 5'd0, 1'b0,
          11'd0, 16'd0},
        '{ROW_FRAME,      FILL_CONST, 8'hFF, 8'd24, FRAME_TYPE_RST + 8'd1, 8'hFF, 5'd0, 1'b0,
          11'd0, 16'd0},
        '{ROW_CUT_FLUSH,  FILL_RAMP, 8'h00, 8'd24, FRAME_TYPE_RST, 8'h00, 5'd13, 1'b0,
          11'd0, 16'd0},
        '{ROW_FLUSH_IDLE, FILL_RAMP, 8'h80, 8'd24, FRAME_TYPE_RST, 8'h01, 5'd0, 1'b0,
          11'd0, 16'd0},
        '{ROW_CUT_FLUSH,  FILL_CONST, 8'hFF, 8'd24, FRAME_TYPE_RST, SYNC_ADDRESS_RST, 5'd25,
          1'b0, 11'd0, 16'd0},
        '{ROW_FRAME,      FILL_RAND, 8'h00, 8'd63, FRAME_TYPE_RST, SYNC_ADDRESS_RST, 5'd0, 1'b0,
          11'd0, 16'd0}
    };

    logic         clk;
    logic         rst_n;
    logic         byte_valid;
    logic         byte_stall;
    byte_item_t   byte_data;
    logic         result_valid;
    logic         result_stall;
    result_item_t result_data;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_index;
    logic [7:0]   cfg_data;

    logic [7:0]   reg_sync   = SYNC_ADDRESS_RST;
    logic [7:0]   reg_type   = FRAME_TYPE_RST;
    logic [7:0]   reg_maxlen = MAX_LENGTH_RST;
    logic [4:0]   frame_pos  = POS_SYNC;
    logic [7:0]   frame_mem [24];
    logic [10:0]  chan_raw [CHANNEL_COUNT];

    result_item_t expected_channels [$];
    byte_item_t   frame_q [$];

    bit           typed_frame  = 1'b0;
    logic [10:0]  typed_raw;
    logic [15:0]  typed_value;
    bit           gaps_enabled = 1'b1;
    int           burst_left   = 0;
    int           hold_request = 0;
    int           frames_decoded = 0;
    int           errors = 0;

    rc_channel_frame_decoder DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .byte_data    (byte_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5000000;
        $display("** rc_channel_frame_decoder: FAILED **");
        $finish;
    end

    function automatic bit decode_byte(byte_item_t it);
        int bitpos;
        int ch;
        int k;
        int idx;
        logic [23:0] acc;
        if (it.operation == OP_FLUSH)
        begin
            frame_pos = POS_SYNC;
            return 1'b0;
        end
        if (frame_pos == POS_SYNC)
        begin
            if (it.data_byte == reg_sync)
                frame_pos = POS_LENGTH;
            return 1'b0;
        end
        if (frame_pos == POS_LENGTH)
        begin
            frame_pos = (it.data_byte > reg_maxlen) ? POS_SYNC : POS_TYPE;
            return 1'b0;
        end
        frame_mem[frame_pos - POS_TYPE] = it.data_byte;
        if (frame_pos != POS_CHECK)
        begin
            frame_pos = frame_pos + 5'd1;
            return 1'b0;
        end
        frame_pos = POS_SYNC;
        if (frame_mem[0] != reg_type)
            return 1'b0;
        for (ch = 0; ch < CHANNEL_COUNT; ch++)
        begin
            bitpos = RAW_W * ch;
            acc = '0;
            for (k = 0; k < 3; k++)
            begin
                idx = 1 + bitpos / 8 + k;
                if (idx < 24)
                    acc = acc | (24'(frame_mem[idx]) << (8 * k));
            end
            chan_raw[ch] = 11'(acc >> (bitpos % 8));
        end
        return 1'b1;
    endfunction

    function automatic void build_frame(logic [7:0] length, logic [7:0] ftype, fill_t mode,
                                        logic [7:0] fill, logic [7:0] check);
        logic [7:0] d;
        int i;
        frame_q.delete();
        frame_q.push_back('{OP_BYTE, reg_sync});
        frame_q.push_back('{OP_BYTE, length});
        frame_q.push_back('{OP_BYTE, ftype});
        for (i = 0; i < DATA_BYTES; i++)
        begin
            case (mode)
                FILL_CONST: d = fill;
                FILL_RAMP:  d = fill + 8'(i * 37 + 5);
                FILL_RAND:  d = 8'($urandom);
                default:
                    case ($urandom_range(0, 2))
                        0:       d = 8'h00;
                        1:       d = 8'hFF;
                        default: d = 8'($urandom);
                    endcase
            endcase
            frame_q.push_back('{OP_BYTE, d});
        end
        frame_q.push_back('{OP_BYTE, check});
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    task automatic send_item(byte_item_t it);
        int gap;
        int ch;
        result_item_t r;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = 0;
            if (gaps_enabled)
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 5);
            if (gap > 0)
            begin
                byte_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        byte_valid <= 1'b1;
        byte_data  <= it;
        do @(posedge clk); while (byte_stall);
        if (decode_byte(it))
        begin
            frames_decoded++;
            for (ch = 0; ch < CHANNEL_COUNT; ch++)
            begin
                r.channel_index = CH_W'(ch);
                r.raw_value     = typed_frame ? typed_raw : chan_raw[ch];
                r.channel_value = typed_frame ? typed_value
                                : 16'((32'(chan_raw[ch]) * 65535) / 32'(RAW_MAX));
                r.last_channel  = (ch == CHANNEL_COUNT - 1);
                expected_channels.push_back(r);
            end
        end
    endtask

    task automatic send_frame(int count);
        int i;
        for (i = 0; i < count; i++)
            send_item(frame_q[i]);
    endtask

    task automatic drain_results(int settle_cycles);
        byte_valid <= 1'b0;
        do @(posedge clk); while (expected_channels.size() != 0);
        repeat (settle_cycles) @(posedge clk);
        burst_left = 0;
    endtask

    task automatic write_settings(logic [7:0] sync_v, logic [7:0] type_v, logic [7:0] len_v);
        logic [1:0] idx [3];
        logic [7:0] val [3];
        int i;
        idx = '{CFG_SYNC_ADDRESS, CFG_FRAME_TYPE, CFG_MAX_LENGTH};
        val = '{sync_v, type_v, len_v};
        for (i = 0; i < 3; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do @(posedge clk); while (!cfg_ready);
            case (idx[i])
                CFG_SYNC_ADDRESS: reg_sync   = val[i];
                CFG_FRAME_TYPE:   reg_type   = val[i];
                default:          reg_maxlen = val[i];
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(int quota);
        int sent;
        int base;
        int pick;
        int cut;
        sent = 0;
        base = frames_decoded;
        while (sent < quota || frames_decoded - base < 2)
        begin
            pick = $urandom_range(0, 99);
            gaps_enabled = ($urandom_range(0, 4) != 0);
            build_frame(8'($urandom_range(0, reg_maxlen)),
                        ($urandom_range(0, 6) != 0) ? reg_type : 8'($urandom),
                        fill_t'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
            if (pick < 65)
            begin
                send_frame(FRAME_BYTES);
                sent += FRAME_BYTES;
            end
            else if (pick < 75)
            begin
                repeat ($urandom_range(1, 3)) send_item('{OP_BYTE, 8'($urandom)});
            end
            else if (pick < 83)
            begin
                if (reg_maxlen != 8'hFF)
                    frame_q[1].data_byte = 8'($urandom_range(reg_maxlen + 1, 255));
                send_frame(FRAME_BYTES);
                sent += 2;
            end
            else if (pick < 93)
            begin
                cut = $urandom_range(0, FRAME_BYTES - 1);
                send_frame(cut);
                send_item('{OP_FLUSH, 8'($urandom)});
                sent += cut + 1;
            end
            else
            begin
                cut = $urandom_range(3, FRAME_BYTES - 2);
                send_frame(cut);
                sent += cut;
            end
        end
        send_item('{OP_FLUSH, 8'($urandom)});
    endtask

    // receiver: changing stall pattern, with a long hold-off on request
    initial
    begin
        int mode;
        int mode_left;
        int n;
        mode = 0;
        mode_left = 0;
        result_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                n = hold_request;
                hold_request = 0;
                result_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 150);
            end
            mode_left--;
            case (mode)
                0:       result_stall <= 1'b0;
                1:       result_stall <= ($urandom_range(0, 99) < 30);
                2:       result_stall <= (mode_left % 3 == 0);
                default: result_stall <= ($urandom_range(0, 99) < 75);
            endcase
        end
    end

    always @(posedge clk)
    begin
        result_item_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_channels.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected channel %0d raw %0d value %0d", $time,
                         result_data.channel_index, result_data.raw_value,
                         result_data.channel_value);
            end
            else
            begin
                want = expected_channels.pop_front();
                check_field("channel_index", 16'(want.channel_index),
                            16'(result_data.channel_index));
                check_field("channel_value", want.channel_value, result_data.channel_value);
                check_field("raw_value", 16'(want.raw_value), 16'(result_data.raw_value));
                check_field("last_channel", 16'(want.last_channel),
                            16'(result_data.last_channel));
            end
        end
    end

    initial
    begin
        stim_row_t row;
        int p;
        rst_n      <= 1'b0;
        byte_valid <= 1'b0;
        byte_data  <= '0;
        cfg_valid  <= 1'b0;
        cfg_index  <= CFG_SYNC_ADDRESS;
        cfg_data   <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        foreach (stim_table[r])
        begin
            row = stim_table[r];
            build_frame(row.length, row.ftype, row.fill_mode, row.fill, row.check);
            if (row.kind == ROW_BAD_SYNC)
                send_item('{OP_BYTE, reg_sync ^ 8'h01});
            if (row.kind == ROW_FLUSH_IDLE)
                send_item('{OP_FLUSH, reg_sync});
            typed_frame = row.typed;
            typed_raw   = row.t_raw;
            typed_value = row.t_value;
            send_frame((row.kind == ROW_CUT_FLUSH) ? int'(row.cut) : FRAME_BYTES);
            if (row.kind == ROW_CUT_FLUSH)
                send_item('{OP_FLUSH, row.fill});
            typed_frame = 1'b0;
        end
        drain_results(0);

        // hold the result side while frames keep coming, so the byte side backs up
        hold_request = 200;
        gaps_enabled = 1'b0;
        repeat (2)
        begin
            build_frame(8'd24, reg_type, FILL_RAND, 8'h00, 8'($urandom));
            send_frame(FRAME_BYTES);
        end
        gaps_enabled = 1'b1;

        for (p = 0; p < 4; p++)
        begin
            drain_results(40);
            case (p)
                0:       write_settings(8'h00, 8'hFF, 8'h00);
                1:       write_settings(8'hFF, 8'h00, 8'hFF);
                2:       write_settings(8'($urandom), 8'($urandom), 8'($urandom));
                default: write_settings(SYNC_ADDRESS_RST, FRAME_TYPE_RST, MAX_LENGTH_RST);
            endcase
            if (p == 2)
            begin
                random_phase(20);
                drain_results(0);
                random_phase(20);
            end
            else
                random_phase(40);
        end

        drain_results(64);
        if (errors == 0 && expected_channels.size() == 0)
            $display("** rc_channel_frame_decoder: PASSED **");
        else
            $display("** rc_channel_frame_decoder: FAILED **");
        $finish;
    end

endmodule
